### rtl/vfc_pkg.sv
package vfc_pkg;

   localparam int CHUNK_WIDTH   = 16;
   localparam int COLUMN_HEIGHT = 128;
   localparam int PADDED        = CHUNK_WIDTH + 2;
   localparam int STORE_DEPTH   = PADDED * PADDED * COLUMN_HEIGHT;
   localparam int ADDR_W        = $clog2(STORE_DEPTH);

   localparam int COORD_W   = 5;
   localparam int HEIGHT_W  = 7;
   localparam int TYPE_W    = 3;
   localparam int DIR_W     = 3;
   localparam int NUM_DIRS  = 6;
   localparam int NUM_READS = NUM_DIRS + 1;
   localparam int STEP_W    = $clog2(NUM_READS);

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_MESH  = 1'b1;

   localparam logic [TYPE_W-1:0] VT_AIR   = TYPE_W'(0);
   localparam logic [TYPE_W-1:0] VT_WATER = TYPE_W'(1);

   localparam logic [DIR_W-1:0] DIR_POS_X = DIR_W'(0);
   localparam logic [DIR_W-1:0] DIR_NEG_X = DIR_W'(1);
   localparam logic [DIR_W-1:0] DIR_POS_Y = DIR_W'(2);
   localparam logic [DIR_W-1:0] DIR_NEG_Y = DIR_W'(3);
   localparam logic [DIR_W-1:0] DIR_POS_Z = DIR_W'(4);
   localparam logic [DIR_W-1:0] DIR_NEG_Z = DIR_W'(5);

   localparam logic [STEP_W-1:0] STEP_SELF  = STEP_W'(0);
   localparam logic [STEP_W-1:0] STEP_POS_X = STEP_W'(1);
   localparam logic [STEP_W-1:0] STEP_NEG_X = STEP_W'(2);
   localparam logic [STEP_W-1:0] STEP_POS_Y = STEP_W'(3);
   localparam logic [STEP_W-1:0] STEP_NEG_Y = STEP_W'(4);
   localparam logic [STEP_W-1:0] STEP_POS_Z = STEP_W'(5);
   localparam logic [STEP_W-1:0] STEP_NEG_Z = STEP_W'(6);

   typedef struct packed {
      logic                operation;
      logic [COORD_W-1:0]  pos_x;
      logic [COORD_W-1:0]  pos_y;
      logic [HEIGHT_W-1:0] pos_z;
      logic [TYPE_W-1:0]   voxel_type;
   } req_type;

   typedef struct packed {
      logic [COORD_W-1:0]  face_x;
      logic [COORD_W-1:0]  face_y;
      logic [HEIGHT_W-1:0] face_z;
      logic [DIR_W-1:0]    face_dir;
      logic [TYPE_W-1:0]   face_type;
      logic                water_section;
      logic                top_lowered;
      logic                last_face;
   } rsp_type;

   typedef struct packed {
      logic                wr_en;
      logic                rd_en;
      logic [COORD_W-1:0]  x;
      logic [COORD_W-1:0]  y;
      logic [HEIGHT_W-1:0] z;
      logic [TYPE_W-1:0]   wr_type;
   } mem_req_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_DRAIN,
      ST_EVAL,
      ST_EMIT
   } ctrl_state_type;

endpackage

### rtl/vfc_store.sv
module vfc_store (
   input  logic                        clock,
   input  vfc_pkg::mem_req_type        mem_req,
   output logic [vfc_pkg::TYPE_W-1:0]  rd_type
);
   import vfc_pkg::*;

   logic [TYPE_W-1:0] mem [STORE_DEPTH];
   logic [TYPE_W-1:0] rd_type_ff;
   logic [ADDR_W-1:0] addr;

   assign addr = ADDR_W'(int'(mem_req.x) * (PADDED * COLUMN_HEIGHT)
                       + int'(mem_req.y) * COLUMN_HEIGHT
                       + int'(mem_req.z));

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[addr] <= mem_req.wr_type;
      end
      if (mem_req.rd_en) begin
         rd_type_ff <= mem[addr];
      end
   end

   assign rd_type = rd_type_ff;

endmodule

### rtl/vfc_ctrl.sv
module vfc_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        show_border,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  vfc_pkg::req_type            req_payload,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output vfc_pkg::rsp_type            rsp_payload,
   output vfc_pkg::mem_req_type        mem_req,
   input  logic [vfc_pkg::TYPE_W-1:0]  rd_type
);
   import vfc_pkg::*;

   ctrl_state_type state_ff, state_in;

   logic [COORD_W-1:0]  pos_x_ff, pos_x_in;
   logic [COORD_W-1:0]  pos_y_ff, pos_y_in;
   logic [HEIGHT_W-1:0] pos_z_ff, pos_z_in;
   logic [STEP_W-1:0]   step_ff, step_in;

   logic                cap_valid_ff;
   logic [STEP_W-1:0]   cap_step_ff;
   logic                cap_air_ff;
   logic                read_air;
   logic [TYPE_W-1:0]   types_ff [NUM_READS];

   logic [NUM_DIRS-1:0] mask_ff, mask_in;
   logic                lowered_ff, lowered_in;
   logic [NUM_DIRS-1:0] eval_mask;
   logic                eval_lowered;

   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;
   logic                load;
   logic [DIR_W-1:0]    sel_dir;
   logic [NUM_DIRS-1:0] mask_rest;

   logic req_fire;
   logic req_in_volume;
   logic req_interior;

   function automatic logic [DIR_W-1:0] lowest_dir(input logic [NUM_DIRS-1:0] m);
      logic [DIR_W-1:0] r;
      r = DIR_W'(0);
      for (int i = NUM_DIRS - 1; i >= 0; i--) begin
         if (m[i]) begin
            r = DIR_W'(i);
         end
      end
      return r;
   endfunction

   assign req_fire      = req_valid && req_ready;
   assign req_in_volume = (int'(req_payload.pos_x) < PADDED)
                       && (int'(req_payload.pos_y) < PADDED)
                       && (int'(req_payload.pos_z) < COLUMN_HEIGHT);
   assign req_interior  = (int'(req_payload.pos_x) >= 1)
                       && (int'(req_payload.pos_x) <= CHUNK_WIDTH)
                       && (int'(req_payload.pos_y) >= 1)
                       && (int'(req_payload.pos_y) <= CHUNK_WIDTH)
                       && (int'(req_payload.pos_z) < COLUMN_HEIGHT);

   always_comb begin
      logic water;
      logic nb_show;
      logic border;
      water        = (types_ff[STEP_SELF] == VT_WATER);
      eval_lowered = water && (types_ff[STEP_POS_Z] != VT_WATER);
      for (int d = 0; d < NUM_DIRS; d++) begin
         if (water) begin
            nb_show = (types_ff[d + 1] == VT_AIR);
         end else begin
            nb_show = (types_ff[d + 1] == VT_AIR) || (types_ff[d + 1] == VT_WATER);
         end
         case (DIR_W'(d))
            DIR_POS_X: border = (pos_x_ff == COORD_W'(CHUNK_WIDTH));
            DIR_NEG_X: border = (pos_x_ff == COORD_W'(1));
            DIR_POS_Y: border = (pos_y_ff == COORD_W'(CHUNK_WIDTH));
            DIR_NEG_Y: border = (pos_y_ff == COORD_W'(1));
            DIR_POS_Z: border = (pos_z_ff == HEIGHT_W'(COLUMN_HEIGHT - 1));
            default:   border = (pos_z_ff == HEIGHT_W'(0));
         endcase
         eval_mask[d] = (types_ff[STEP_SELF] != VT_AIR)
                     && (nb_show || (border && show_border));
      end
   end

   assign sel_dir   = lowest_dir(mask_ff);
   assign mask_rest = mask_ff & ~(NUM_DIRS'(1) << sel_dir);
   assign load      = (state_ff == ST_EMIT) && (mask_ff != '0)
                   && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_payload.operation == OP_MESH && req_interior) begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            if (step_ff == STEP_NEG_Z) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: state_in = ST_EVAL;
         ST_EVAL:  state_in = ST_EMIT;
         ST_EMIT: begin
            if (mask_ff == '0 || (load && mask_rest == '0)) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready  = (state_ff == ST_IDLE);
      pos_x_in   = pos_x_ff;
      pos_y_in   = pos_y_ff;
      pos_z_in   = pos_z_ff;
      step_in    = step_ff;
      mask_in    = mask_ff;
      lowered_in = lowered_ff;
      read_air   = 1'b0;

      mem_req         = '0;
      mem_req.x       = pos_x_ff;
      mem_req.y       = pos_y_ff;
      mem_req.z       = pos_z_ff;
      mem_req.wr_type = req_payload.voxel_type;

      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      unique case (state_ff)
         ST_IDLE: begin
            mem_req.x = req_payload.pos_x;
            mem_req.y = req_payload.pos_y;
            mem_req.z = req_payload.pos_z;
            if (req_fire && req_payload.operation == OP_WRITE) begin
               mem_req.wr_en = req_in_volume;
            end
            pos_x_in = req_payload.pos_x;
            pos_y_in = req_payload.pos_y;
            pos_z_in = req_payload.pos_z;
            step_in  = STEP_SELF;
         end
         ST_FETCH: begin
            mem_req.rd_en = 1'b1;
            case (step_ff)
               STEP_POS_X: mem_req.x = pos_x_ff + COORD_W'(1);
               STEP_NEG_X: mem_req.x = pos_x_ff - COORD_W'(1);
               STEP_POS_Y: mem_req.y = pos_y_ff + COORD_W'(1);
               STEP_NEG_Y: mem_req.y = pos_y_ff - COORD_W'(1);
               STEP_POS_Z: begin
                  mem_req.z = pos_z_ff + HEIGHT_W'(1);
                  read_air  = (pos_z_ff == HEIGHT_W'(COLUMN_HEIGHT - 1));
               end
               STEP_NEG_Z: begin
                  mem_req.z = pos_z_ff - HEIGHT_W'(1);
                  read_air  = (pos_z_ff == HEIGHT_W'(0));
               end
               default: ;
            endcase
            step_in = step_ff + STEP_W'(1);
         end
         ST_DRAIN: ;
         ST_EVAL: begin
            mask_in    = eval_mask;
            lowered_in = eval_lowered;
         end
         ST_EMIT: begin
            if (load) begin
               rsp_in.face_x        = pos_x_ff;
               rsp_in.face_y        = pos_y_ff;
               rsp_in.face_z        = pos_z_ff;
               rsp_in.face_dir      = sel_dir;
               rsp_in.face_type     = types_ff[STEP_SELF];
               rsp_in.water_section = (types_ff[STEP_SELF] == VT_WATER);
               rsp_in.top_lowered   = lowered_ff;
               rsp_in.last_face     = (mask_rest == '0);
               rsp_valid_in         = 1'b1;
               mask_in              = mask_rest;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cap_valid_ff <= 1'b0;
         step_ff      <= STEP_SELF;
         mask_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cap_valid_ff <= mem_req.rd_en;
         step_ff      <= step_in;
         mask_ff      <= mask_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_x_ff    <= pos_x_in;
      pos_y_ff    <= pos_y_in;
      pos_z_ff    <= pos_z_in;
      lowered_ff  <= lowered_in;
      rsp_ff      <= rsp_in;
      cap_step_ff <= step_ff;
      cap_air_ff  <= read_air;
      if (cap_valid_ff) begin
         types_ff[cap_step_ff] <= cap_air_ff ? VT_AIR : rd_type;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_no_write_while_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !mem_req.wr_en)
      else $error("Voxel store written while a mesh item is in progress.");

   a_fetch_step_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FETCH) |-> (int'(step_ff) < NUM_READS))
      else $error("Fetch step beyond the last neighbour read.");

   a_last_face_ends_item: assert property (@(posedge clock) disable iff (reset)
      (load && rsp_in.last_face) |=> (state_ff == ST_IDLE))
      else $error("Sequencer did not return to idle after the last face.");

   a_capture_follows_read: assert property (@(posedge clock) disable iff (reset)
      mem_req.rd_en |=> cap_valid_ff)
      else $error("Read data from the voxel store was not captured.");

   a_emit_mask_shrinks: assert property (@(posedge clock) disable iff (reset)
      load |=> ($countones(mask_ff) == $countones($past(mask_ff)) - 1))
      else $error("Face mask did not lose exactly one face on a transfer.");

endmodule

### rtl/voxel_face_culling.sv
// Writes may be accepted in consecutive cycles.
// A mesh item makes seven reads through the single voxel store port, then passes
// through a drain and an evaluation state; its faces are then registered one per
// cycle while the receiver is ready.
// Reset is synchronous and clears the sequencer, the output valid and the border
// register; the voxel store is not cleared and is undefined until written.
module voxel_face_culling (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  vfc_pkg::req_type  req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output vfc_pkg::rsp_type  rsp_payload,
   input  logic              csr_write_enable,
   input  logic              csr_write_data
);
   import vfc_pkg::*;

   logic              show_border_ff;
   mem_req_type       mem_req;
   logic [TYPE_W-1:0] rd_type;

   always_ff @(posedge clock) begin
      if (reset) begin
         show_border_ff <= 1'b0;
      end else if (csr_write_enable) begin
         show_border_ff <= csr_write_data;
      end
   end

   vfc_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .show_border (show_border_ff),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .mem_req     (mem_req),
      .rd_type     (rd_type)
   );

   vfc_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_type (rd_type)
   );

endmodule

### bench/testbench.sv
module testbench;
   import vfc_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int SETTLE_CYCLES  = 20;
   localparam int COORD_MAX      = 2 ** COORD_W - 1;

   localparam logic [TYPE_W-1:0] VT_SAND    = TYPE_W'(2);
   localparam logic [TYPE_W-1:0] VT_DIRT    = TYPE_W'(3);
   localparam logic [TYPE_W-1:0] VT_GRASS   = TYPE_W'(4);
   localparam logic [TYPE_W-1:0] VT_BEDROCK = TYPE_W'(5);
   localparam logic [TYPE_W-1:0] VT_STONE   = TYPE_W'(6);
   localparam logic [TYPE_W-1:0] VT_SPARE   = TYPE_W'(7);

   class culled_face_book;
      bit [TYPE_W-1:0] cells [STORE_DEPTH];
      bit              written [STORE_DEPTH];
      bit              border_on;
      rsp_type         expected_faces [$];
      int              errors;
      int              writes_kept;
      int              meshes_done;
      int              faces_checked;

      function bit in_volume(int x, int y, int z);
         return x >= 0 && x < PADDED && y >= 0 && y < PADDED && z >= 0 && z < COLUMN_HEIGHT;
      endfunction

      function int slot(int x, int y, int z);
         return z + COLUMN_HEIGHT * (y + PADDED * x);
      endfunction

      function logic [TYPE_W-1:0] voxel_at(int x, int y, int z);
         if (!in_volume(x, y, z)) return VT_AIR;
         return cells[slot(x, y, z)];
      endfunction

      function bit known(int x, int y, int z);
         return !in_volume(x, y, z) || written[slot(x, y, z)];
      endfunction

      function int pending();
         return expected_faces.size();
      endfunction

      function void note_request(req_type item);
         int                x, y, z, nx, ny, nz;
         bit                water, lowered, at_rim, show;
         logic [TYPE_W-1:0] self_type, near;
         logic [DIR_W-1:0]  dirs [6];
         rsp_type           face;
         rsp_type           faces [$];
         x = item.pos_x;
         y = item.pos_y;
         z = item.pos_z;
         dirs = '{DIR_POS_X, DIR_NEG_X, DIR_POS_Y, DIR_NEG_Y, DIR_POS_Z, DIR_NEG_Z};
         if (item.operation == OP_WRITE) begin
            if (in_volume(x, y, z)) begin
               cells[slot(x, y, z)] = item.voxel_type;
               written[slot(x, y, z)] = 1'b1;
               writes_kept++;
            end
            return;
         end
         if (x < 1 || x > CHUNK_WIDTH || y < 1 || y > CHUNK_WIDTH || z >= COLUMN_HEIGHT)
            return;
         meshes_done++;
         self_type = voxel_at(x, y, z);
         if (self_type == VT_AIR) return;
         water = self_type == VT_WATER;
         lowered = water && voxel_at(x, y, z + 1) != VT_WATER;
         foreach (dirs[i]) begin
            nx = x;
            ny = y;
            nz = z;
            at_rim = 1'b0;
            case (dirs[i])
               DIR_POS_X: begin
                  nx = x + 1;
                  at_rim = x == CHUNK_WIDTH;
               end
               DIR_NEG_X: begin
                  nx = x - 1;
                  at_rim = x == 1;
               end
               DIR_POS_Y: begin
                  ny = y + 1;
                  at_rim = y == CHUNK_WIDTH;
               end
               DIR_NEG_Y: begin
                  ny = y - 1;
                  at_rim = y == 1;
               end
               DIR_POS_Z: begin
                  nz = z + 1;
                  at_rim = z == COLUMN_HEIGHT - 1;
               end
               DIR_NEG_Z: begin
                  nz = z - 1;
                  at_rim = z == 0;
               end
               default: begin
               end
            endcase
            near = voxel_at(nx, ny, nz);
            show = water ? near == VT_AIR : (near == VT_AIR || near == VT_WATER);
            if (show || (at_rim && border_on)) begin
               face.face_x        = item.pos_x;
               face.face_y        = item.pos_y;
               face.face_z        = item.pos_z;
               face.face_dir      = dirs[i];
               face.face_type     = self_type;
               face.water_section = water;
               face.top_lowered   = lowered;
               face.last_face     = 1'b0;
               faces.push_back(face);
            end
         end
         if (faces.size() > 0) faces[faces.size() - 1].last_face = 1'b1;
         foreach (faces[i]) expected_faces.push_back(faces[i]);
      endfunction

      function void compare_field(string name, logic [7:0] want, logic [7:0] seen);
         if (want !== seen) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, seen);
            errors++;
         end
      endfunction

      function void check_face(rsp_type got);
         rsp_type want;
         if (expected_faces.size() == 0) begin
            $display("%0t: face record arrived, expected none, got %h", $time, got);
            errors++;
            return;
         end
         want = expected_faces.pop_front();
         faces_checked++;
         compare_field("face_x", want.face_x, got.face_x);
         compare_field("face_y", want.face_y, got.face_y);
         compare_field("face_z", want.face_z, got.face_z);
         compare_field("face_dir", want.face_dir, got.face_dir);
         compare_field("face_type", want.face_type, got.face_type);
         compare_field("water_section", want.water_section, got.water_section);
         compare_field("top_lowered", want.top_lowered, got.top_lowered);
         compare_field("last_face", want.last_face, got.last_face);
      endfunction
   endclass

   logic    clock            = 1'b0;
   logic    reset            = 1'b1;
   logic    req_valid        = 1'b0;
   logic    req_ready;
   req_type req_payload      = '0;
   logic    rsp_valid;
   logic    rsp_ready        = 1'b0;
   rsp_type rsp_payload;
   logic    csr_write_enable = 1'b0;
   logic    csr_write_data   = 1'b0;

   bit calm         = 1'b0;
   int stall_left   = 0;
   int quiet_cycles = 0;
   int near_dx [7]  = '{0, 1, -1, 0, 0, 0, 0};
   int near_dy [7]  = '{0, 0, 0, 1, -1, 0, 0};
   int near_dz [7]  = '{0, 0, 0, 0, 0, 1, -1};

   culled_face_book face_book;

   voxel_face_culling i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic int pick_gap();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [TYPE_W-1:0] pick_type();
      int r;
      r = $urandom_range(0, 9);
      if (r < 3) return VT_AIR;
      if (r < 6) return VT_WATER;
      if (r < 9) return TYPE_W'($urandom_range(VT_SAND, VT_STONE));
      return VT_SPARE;
   endfunction

   function automatic int pick_column();
      case ($urandom_range(0, 3))
         0: return 1;
         1: return CHUNK_WIDTH;
         default: return $urandom_range(1, CHUNK_WIDTH);
      endcase
   endfunction

   function automatic req_type make_req(logic op, int x, int y, int z, int kind);
      req_type item;
      item.operation  = op;
      item.pos_x      = COORD_W'(x);
      item.pos_y      = COORD_W'(y);
      item.pos_z      = HEIGHT_W'(z);
      item.voxel_type = TYPE_W'(kind);
      return item;
   endfunction

   // The receiver holds ready low for a randomly drawn number of cycles after each high cycle.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) face_book.check_face(rsp_payload);
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         stall_left = pick_gap();
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic send_req(req_type item);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (req_ready !== 1'b1);
      face_book.note_request(item);
   endtask

   task automatic put_voxel(int x, int y, int z, int kind);
      send_req(make_req(OP_WRITE, x, y, z, kind));
   endtask

   // Every in-volume cell that a mesh transfer may read is written first, unless it was already written.
   task automatic send_mesh(int x, int y, int z);
      for (int k = 0; k < 7; k++)
         if (!face_book.known(x + near_dx[k], y + near_dy[k], z + near_dz[k]))
            put_voxel(x + near_dx[k], y + near_dy[k], z + near_dz[k], pick_type());
      send_req(make_req(OP_MESH, x, y, z, $urandom_range(VT_AIR, VT_SPARE)));
   endtask

   task automatic wait_quiet();
      req_valid <= 1'b0;
      while (face_book.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_border(bit value);
      wait_quiet();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      face_book.border_on = value;
   endtask

   task automatic random_cluster();
      int cx, cy, cz, k;
      cx = pick_column();
      cy = pick_column();
      case ($urandom_range(0, 3))
         0: cz = 0;
         1: cz = COLUMN_HEIGHT - 1;
         default: cz = $urandom_range(0, COLUMN_HEIGHT - 1);
      endcase
      for (k = 0; k < 7; k++)
         if (face_book.in_volume(cx + near_dx[k], cy + near_dy[k], cz + near_dz[k]))
            put_voxel(cx + near_dx[k], cy + near_dy[k], cz + near_dz[k], pick_type());
      send_mesh(cx, cy, cz);
      k = $urandom_range(1, 6);
      if ($urandom_range(0, 1) == 1 && cz + near_dz[k] >= 0 && cz + near_dz[k] < COLUMN_HEIGHT)
         send_mesh(cx + near_dx[k], cy + near_dy[k], cz + near_dz[k]);
   endtask

   task automatic random_noise();
      case ($urandom_range(0, 3))
         0: put_voxel($urandom_range(PADDED, COORD_MAX), $urandom_range(0, COORD_MAX),
                      $urandom_range(0, COLUMN_HEIGHT - 1), $urandom_range(VT_AIR, VT_SPARE));
         1: send_mesh($urandom_range(0, 1) == 1 ? 0 : $urandom_range(CHUNK_WIDTH + 1, COORD_MAX),
                      $urandom_range(0, COORD_MAX), $urandom_range(0, COLUMN_HEIGHT - 1));
         2: put_voxel($urandom_range(0, PADDED - 1), $urandom_range(0, PADDED - 1),
                      $urandom_range(0, COLUMN_HEIGHT - 1), $urandom_range(VT_AIR, VT_SPARE));
         default: send_mesh($urandom_range(1, CHUNK_WIDTH), $urandom_range(1, CHUNK_WIDTH),
                            $urandom_range(0, COLUMN_HEIGHT - 1));
      endcase
   endtask

   initial begin
      bit border_plan [3];
      int goal;
      int half;
      bit paused;
      int mx;
      int my;
      int mz;
      border_plan = '{1'b1, 1'b0, 1'b1};
      mx = CHUNK_WIDTH / 2;
      my = CHUNK_WIDTH / 2;
      mz = COLUMN_HEIGHT / 2;
      face_book = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      set_border(1'b0);

      put_voxel(COORD_MAX, COORD_MAX, COLUMN_HEIGHT - 1, VT_SPARE);
      put_voxel(0, 0, 0, VT_AIR);
      put_voxel(CHUNK_WIDTH, CHUNK_WIDTH, COLUMN_HEIGHT - 1, VT_WATER);
      put_voxel(CHUNK_WIDTH + 1, CHUNK_WIDTH, COLUMN_HEIGHT - 1, VT_SPARE);
      put_voxel(CHUNK_WIDTH - 1, CHUNK_WIDTH, COLUMN_HEIGHT - 1, VT_AIR);
      put_voxel(CHUNK_WIDTH, CHUNK_WIDTH + 1, COLUMN_HEIGHT - 1, VT_AIR);
      put_voxel(CHUNK_WIDTH, CHUNK_WIDTH - 1, COLUMN_HEIGHT - 1, VT_WATER);
      put_voxel(CHUNK_WIDTH, CHUNK_WIDTH, COLUMN_HEIGHT - 2, VT_WATER);
      send_mesh(CHUNK_WIDTH, CHUNK_WIDTH, COLUMN_HEIGHT - 1);
      put_voxel(mx, my, mz, VT_SPARE);
      put_voxel(mx + 1, my, mz, VT_SAND);
      put_voxel(mx - 1, my, mz, VT_DIRT);
      put_voxel(mx, my + 1, mz, VT_GRASS);
      put_voxel(mx, my - 1, mz, VT_BEDROCK);
      put_voxel(mx, my, mz + 1, VT_STONE);
      put_voxel(mx, my, mz - 1, VT_STONE);
      send_mesh(mx, my, mz);
      send_mesh(COORD_MAX, COORD_MAX, COLUMN_HEIGHT - 1);
      put_voxel(1, 1, 0, VT_STONE);
      send_mesh(1, 1, 0);

      for (int p = 0; p < 3; p++) begin
         set_border(border_plan[p]);
         calm = p == 1;
         goal = face_book.writes_kept + face_book.meshes_done + 28;
         half = goal - 14;
         paused = 1'b0;
         while (face_book.writes_kept + face_book.meshes_done < goal) begin
            if (!paused && face_book.writes_kept + face_book.meshes_done >= half) begin
               wait_quiet();
               paused = 1'b1;
               calm = 1'b0;
            end
            if ($urandom_range(0, 3) == 0) random_noise();
            else random_cluster();
         end
      end

      wait_quiet();
      $display("Run covered %0d voxel writes and %0d mesh transfers, %0d face records checked.",
               face_book.writes_kept, face_book.meshes_done, face_book.faces_checked);
      $display("Border faces were exercised off and on, with gaps and stalls on both channels.");
      if (face_book.errors == 0 && face_book.pending() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
